[hdl/fat_dir_entry_scanner_core_assert.svh]
// Assertion macros shared by the directory entry scanner modules.
`ifndef FAT_DIR_ENTRY_SCANNER_CORE_ASSERT_SVH
`define FAT_DIR_ENTRY_SCANNER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FDES_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("fdes assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FDES_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("fdes assertion failed");

`endif

[hdl/fdes_pkg.sv]
// Package with constants, types and register codes of the directory entry scanner.
`default_nettype none

package fdes_pkg;

  localparam int unsigned MaxEntries = 512;
  localparam int unsigned EntryBytes = 32;
  localparam int unsigned PosW       = $clog2(EntryBytes);
  localparam int unsigned IdxW       = 10;
  localparam int unsigned RootW      = 28;
  localparam int unsigned MaxLimW    = $clog2(MaxEntries + 1);
  localparam int unsigned LimW       = (IdxW > MaxLimW) ? IdxW : MaxLimW;
  localparam int unsigned NameSlots  = 12;
  localparam int unsigned QDepth     = 2;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 28;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgFat32Mode   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRootCluster = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgEntryLimit  = 2'd2;

  localparam logic [RootW-1:0] RootReset  = 28'd2;
  localparam logic [IdxW-1:0]  LimitReset = 10'd512;

  // Directory entry byte codes and offsets.
  localparam logic [7:0] EndByte     = 8'h00;
  localparam logic [7:0] DeletedMark = 8'hE5;
  localparam logic [7:0] KanjiEsc    = 8'h05;
  localparam logic [7:0] SpaceChar   = 8'h20;
  localparam logic [7:0] DotChar     = 8'h2E;
  localparam logic [7:0] AttrMask    = 8'h1E;
  localparam logic [7:0] AttrDir     = 8'h10;
  localparam logic [PosW-1:0] AttrOfs   = 5'h0B;
  localparam logic [PosW-1:0] LenOfs    = 5'h1C;
  localparam logic [PosW-1:0] ClusLoOfs = 5'h1A;
  localparam logic [PosW-1:0] ClusHiOfs = 5'h14;

  typedef struct packed {
    logic             fat32_mode;
    logic [RootW-1:0] root_clus;
    logic [IdxW-1:0]  entry_limit;
  } cfg_t;

  // One judged entry or an end marker, as handed from front to back.
  typedef struct packed {
    logic                          is_end;
    logic [NameSlots-1:0][7:0]     chars;
    logic [NameSlots-1:0]          mask;
    logic                          is_dir;
    logic [31:0]                   len;
    logic [31:0]                   clus;
  } desc_t;

endpackage

`default_nettype wire

[hdl/fdes_stream_if.sv]
// Handshake interfaces for the directory byte stream and the result stream.
`default_nettype none

interface fdes_in_if;
  logic       valid;
  logic       ready;
  logic       restart;
  logic [7:0] dir_byte;

  modport source (output valid, output restart, output dir_byte, input ready);
  modport sink (input valid, input restart, input dir_byte, output ready);
endinterface

interface fdes_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  name_char;
  logic        is_directory;
  logic [31:0] file_length;
  logic [31:0] first_cluster;
  logic        last;

  modport source (output valid, output kind, output name_char, output is_directory,
                  output file_length, output first_cluster, output last, input ready);
  modport sink (input valid, input kind, input name_char, input is_directory,
                input file_length, input first_cluster, input last, output ready);
endinterface

`default_nettype wire

[hdl/fdes_front.sv]
// Front part: takes directory bytes, buffers each entry and judges it on its last byte.
`default_nettype none

module fdes_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire fdes_pkg::cfg_t cfg_i,
  fdes_in_if.sink            in_s,
  input  wire logic          q_full_i,
  output logic               push_o,
  output fdes_pkg::desc_t    desc_o
);
  import fdes_pkg::*;

  logic [PosW-1:0] pos_q, pos_d, pos_e;
  logic [IdxW-1:0] idx_q, idx_d, idx_e;
  logic            fin_q, fin_d, fin_e;
  logic [7:0]      buf_q [EntryBytes];
  logic [7:0]      eb [EntryBytes];
  logic            acc, wr, lim_hit, keep;
  logic [LimW-1:0] lim;
  logic [7:0]      attr;
  logic [31:0]     clus;
  desc_t           ent;

  assign in_s.ready = !q_full_i;
  assign acc        = in_s.valid && in_s.ready;

  // The last byte of an entry is judged straight from the input.
  always_comb begin
    for (int i = 0; i < EntryBytes - 1; i++) begin
      eb[i] = buf_q[i];
    end
    eb[EntryBytes-1] = in_s.dir_byte;
  end

  always_comb begin
    attr = eb[AttrOfs] & AttrMask;
    keep = (eb[0] != DeletedMark) && ((attr == 8'h00) || (attr == AttrDir));
    clus = {16'h0000, eb[ClusLoOfs + 5'd1], eb[ClusLoOfs]};
    if (cfg_i.fat32_mode) begin
      clus[31:16] = {eb[ClusHiOfs + 5'd1], eb[ClusHiOfs]};
      if (clus == 32'h0) begin
        clus = {{(32 - RootW){1'b0}}, cfg_i.root_clus};
      end
    end

    ent.is_end = 1'b0;
    ent.is_dir = (attr == AttrDir);
    ent.len    = {eb[LenOfs + 5'd3], eb[LenOfs + 5'd2], eb[LenOfs + 5'd1], eb[LenOfs]};
    ent.clus   = clus;
    ent.chars[0] = (eb[0] == KanjiEsc) ? DeletedMark : eb[0];
    ent.mask[0]  = 1'b1;
    for (int i = 1; i < 8; i++) begin
      ent.chars[i] = eb[i];
      ent.mask[i]  = (eb[i] != SpaceChar);
    end
    ent.chars[8] = DotChar;
    ent.mask[8]  = 1'b1;
    for (int i = 9; i < NameSlots; i++) begin
      ent.chars[i] = eb[i-1];
      ent.mask[i]  = (eb[i-1] != SpaceChar);
    end
    // A name that ends in a dot loses that one character.
    if (ent.mask[11]) begin
      if (ent.chars[11] == DotChar) ent.mask[11] = 1'b0;
    end else if (ent.mask[10]) begin
      if (ent.chars[10] == DotChar) ent.mask[10] = 1'b0;
    end else if (ent.mask[9]) begin
      if (ent.chars[9] == DotChar) ent.mask[9] = 1'b0;
    end else begin
      ent.mask[8] = 1'b0;
    end
  end

  always_comb begin
    pos_e = in_s.restart ? '0 : pos_q;
    idx_e = in_s.restart ? '0 : idx_q;
    fin_e = in_s.restart ? 1'b0 : fin_q;
    lim   = (LimW'(cfg_i.entry_limit) < LimW'(MaxEntries)) ?
            LimW'(cfg_i.entry_limit) : LimW'(MaxEntries);
    lim_hit = (LimW'(idx_e) >= lim);

    pos_d  = pos_q;
    idx_d  = idx_q;
    fin_d  = fin_q;
    wr     = 1'b0;
    push_o = 1'b0;
    desc_o = ent;
    if (acc) begin
      pos_d = pos_e;
      idx_d = idx_e;
      fin_d = fin_e;
      if (!fin_e) begin
        if ((pos_e == '0) && (lim_hit || (in_s.dir_byte == EndByte))) begin
          fin_d  = 1'b1;
          push_o = 1'b1;
          desc_o = '0;
          desc_o.is_end = 1'b1;
          desc_o.mask   = NameSlots'(1);
        end else begin
          wr = 1'b1;
          if (pos_e != PosW'(EntryBytes - 1)) begin
            pos_d = pos_e + 1'b1;
          end else begin
            pos_d  = '0;
            idx_d  = idx_e + 1'b1;
            push_o = keep;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      idx_q <= '0;
      fin_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      idx_q <= idx_d;
      fin_q <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      buf_q[pos_e] <= in_s.dir_byte;
    end
  end

endmodule

`default_nettype wire

[hdl/fdes_queue.sv]
// Short queue of judged entries between the front and back parts.
`default_nettype none
`include "fat_dir_entry_scanner_core_assert.svh"

module fdes_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire fdes_pkg::desc_t push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output fdes_pkg::desc_t      pop_data_o,
  output logic                 nempty_o
);
  import fdes_pkg::*;

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  desc_t           mem_q [QDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q;

  assign full_o     = (cnt_q == CntW'(QDepth));
  assign nempty_o   = (cnt_q != '0);
  assign pop_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == PtrW'(QDepth - 1)) ? '0 : wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= (rp_q == PtrW'(QDepth - 1)) ? '0 : rp_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= push_data_i;
    end
  end

  `FDES_ASSERT_IMPL(a_no_overflow, clk_i, rst_ni, push_i, cnt_q < CntW'(QDepth))
  `FDES_ASSERT_IMPL(a_no_underflow, clk_i, rst_ni, pop_i, cnt_q != '0)
  `FDES_ASSERT_NEXT(a_cnt_up, clk_i, rst_ni, push_i && !pop_i, cnt_q == $past(cnt_q) + 1'b1)

endmodule

`default_nettype wire

[hdl/fdes_back.sv]
// Back part: walks the name of a judged entry and sends one result per character.
`default_nettype none
`include "fat_dir_entry_scanner_core_assert.svh"

module fdes_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire fdes_pkg::desc_t desc_i,
  input  wire logic            nempty_i,
  output logic                 pop_o,
  fdes_out_if.source           out_s
);
  import fdes_pkg::*;

  desc_t                cur_q;
  logic [NameSlots-1:0] rem_q, rem_d, sel, rem_nx;
  logic                 act_q, act_d, ov_q, ov_d, adv;
  logic [7:0]           ch;
  logic                 kind_q, dir_q, last_q;
  logic [7:0]           char_q;
  logic [31:0]          len_q, clus_q;

  // Lowest remaining slot is the next character.
  always_comb begin
    sel    = rem_q & (~rem_q + 1'b1);
    rem_nx = rem_q & ~sel;
    ch     = '0;
    for (int i = 0; i < NameSlots; i++) begin
      ch = ch | (cur_q.chars[i] & {8{sel[i]}});
    end
  end

  assign adv   = act_q && (!ov_q || out_s.ready);
  assign pop_o = !act_q && nempty_i;

  always_comb begin
    act_d = act_q;
    rem_d = rem_q;
    ov_d  = ov_q;
    if (ov_q && out_s.ready) begin
      ov_d = 1'b0;
    end
    if (adv) begin
      ov_d  = 1'b1;
      rem_d = rem_nx;
      act_d = (rem_nx != '0);
    end else if (pop_o) begin
      rem_d = desc_i.mask;
      act_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      ov_q  <= 1'b0;
      rem_q <= '0;
    end else begin
      act_q <= act_d;
      ov_q  <= ov_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= desc_i;
    end
    if (adv) begin
      kind_q <= cur_q.is_end;
      char_q <= ch;
      dir_q  <= cur_q.is_dir;
      len_q  <= cur_q.len;
      clus_q <= cur_q.clus;
      last_q <= (rem_nx == '0);
    end
  end

  assign out_s.valid         = ov_q;
  assign out_s.kind          = kind_q;
  assign out_s.name_char     = char_q;
  assign out_s.is_directory  = dir_q;
  assign out_s.file_length   = len_q;
  assign out_s.first_cluster = clus_q;
  assign out_s.last          = last_q;

  `FDES_ASSERT_IMPL(a_end_is_last, clk_i, rst_ni, ov_q && kind_q, last_q)
  `FDES_ASSERT_IMPL(a_active_has_slots, clk_i, rst_ni, act_q, rem_q != '0)

endmodule

`default_nettype wire

[hdl/fat_dir_entry_scanner_core.sv]
// Top level of the FAT 8.3 directory entry scanner: configuration and part wiring.
// The scanner takes one directory byte per cycle and buffers each 32-byte entry in
// flip-flops; on the last byte the entry is judged and, if it is a live file or
// directory, queued in a two-deep entry queue. The result stage then loads the entry
// and, while the receiver takes every result, sends the compacted name one character
// per cycle, 1 to 12 results per entry, so a full entry of 32 bytes drains before the
// next one is complete. An end-of-directory marker is loaded and sent as one result;
// the input stalls only when the entry queue is full, as with restart bytes that end
// the scan on every cycle or a receiver that holds off. Configuration writes take
// effect at the next clock edge; there is no clearing pass after reset.
`default_nettype none

module fat_dir_entry_scanner_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [fdes_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [fdes_pkg::CfgDataW-1:0] cfg_wdata_i,
  fdes_in_if.sink                            in_s,
  fdes_out_if.source                         out_s
);
  import fdes_pkg::*;

  cfg_t  cfg_q;
  desc_t push_desc, pop_desc;
  logic  push, pop, q_full, q_nempty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fat32_mode  <= 1'b0;
      cfg_q.root_clus   <= RootReset;
      cfg_q.entry_limit <= LimitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgFat32Mode:   cfg_q.fat32_mode  <= cfg_wdata_i[0];
        CfgRootCluster: cfg_q.root_clus   <= cfg_wdata_i[RootW-1:0];
        CfgEntryLimit:  cfg_q.entry_limit <= cfg_wdata_i[IdxW-1:0];
        default: ;
      endcase
    end
  end

  fdes_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .in_s     (in_s),
    .q_full_i (q_full),
    .push_o   (push),
    .desc_o   (push_desc)
  );

  fdes_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_desc),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_data_o  (pop_desc),
    .nempty_o    (q_nempty)
  );

  fdes_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .desc_i   (pop_desc),
    .nempty_i (q_nempty),
    .pop_o    (pop),
    .out_s    (out_s)
  );

endmodule

`default_nettype wire

[verif/fat_dir_entry_scanner_core_tb.sv]
// Testbench for the FAT directory entry scanner: directed byte streams checked against a predictor.
module fat_dir_entry_scanner_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fdes_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned HoldCycles  = 400;

  typedef struct packed {
    logic       restart;
    logic [7:0] dir_byte;
  } dir_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  name_char;
    logic        is_dir;
    logic [31:0] len;
    logic [31:0] clus;
    logic        last;
  } dir_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  fdes_in_if  in_if ();
  fdes_out_if out_if ();

  fat_dir_entry_scanner_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_s        (in_if),
    .out_s       (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Stimulus and expectation stores.
  dir_item_t   byte_queue[$];
  dir_result_t name_results[$];
  dir_item_t   drv_item;
  dir_result_t want;
  int unsigned n_pushed   = 0;
  int unsigned n_accepted = 0;
  int unsigned n_errors   = 0;
  int unsigned n_cycles   = 0;
  int unsigned hold_left  = 0;
  logic        hold_req   = 1'b0;
  logic        hold_spent = 1'b0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;

  // Predictor copy of the configuration and the scan state.
  logic             m_fat32 = 1'b0;
  logic [RootW-1:0] m_root  = RootReset;
  logic [IdxW-1:0]  m_limit = LimitReset;
  logic [PosW-1:0]  m_pos   = '0;
  logic [IdxW-1:0]  m_idx   = '0;
  logic             m_done  = 1'b0;
  logic [7:0]       ent_buf [EntryBytes];

  // Scratch entry that the stimulus tasks build before pushing it.
  logic [7:0]       ent [EntryBytes];

  function automatic void scan_byte(logic rs, logic [7:0] b);
    int unsigned lim;
    logic [7:0]  nm [NameSlots];
    int          n;
    logic [7:0]  attr;
    logic        dir;
    logic [31:0] len;
    logic [31:0] clus;
    lim = (m_limit < MaxEntries) ? m_limit : MaxEntries;
    if (rs) begin
      m_pos  = '0;
      m_idx  = '0;
      m_done = 1'b0;
    end
    if (m_done) return;
    if (m_pos == 0 && (int'(m_idx) >= lim || b == EndByte)) begin
      m_done = 1'b1;
      name_results.push_back('{kind: 1'b1, name_char: 8'h00, is_dir: 1'b0, len: 32'h0,
                               clus: 32'h0, last: 1'b1});
      return;
    end
    ent_buf[m_pos] = b;
    if (m_pos != PosW'(EntryBytes - 1)) begin
      m_pos = m_pos + 1'b1;
      return;
    end
    m_pos = '0;
    m_idx = m_idx + 1'b1;
    // The whole entry is in the buffer now; judge it.
    if (ent_buf[0] == DeletedMark) return;
    attr = ent_buf[AttrOfs] & AttrMask;
    if (attr != 8'h00 && attr != AttrDir) return;
    dir  = (attr == AttrDir);
    len  = {ent_buf[LenOfs + 3], ent_buf[LenOfs + 2], ent_buf[LenOfs + 1], ent_buf[LenOfs]};
    clus = {16'h0, ent_buf[ClusLoOfs + 1], ent_buf[ClusLoOfs]};
    if (m_fat32) begin
      clus[31:16] = {ent_buf[ClusHiOfs + 1], ent_buf[ClusHiOfs]};
      if (clus == 32'h0) clus = {4'h0, m_root};
    end
    nm[0] = (ent_buf[0] == KanjiEsc) ? DeletedMark : ent_buf[0];
    n = 1;
    for (int i = 1; i < 8; i++) begin
      if (ent_buf[i] != SpaceChar) begin
        nm[n] = ent_buf[i];
        n++;
      end
    end
    nm[n] = DotChar;
    n++;
    for (int i = 8; i < 11; i++) begin
      if (ent_buf[i] != SpaceChar) begin
        nm[n] = ent_buf[i];
        n++;
      end
    end
    if (nm[n-1] == DotChar) n--;
    for (int i = 0; i < n; i++) begin
      name_results.push_back('{kind: 1'b0, name_char: nm[i], is_dir: dir, len: len,
                               clus: clus, last: (i == n - 1)});
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      n_errors++;
    end
  endfunction

  task automatic push_byte(logic rs, logic [7:0] b);
    byte_queue.push_back('{restart: rs, dir_byte: b});
    n_pushed++;
  endtask

  task automatic fill_entry(logic [7:0] first, logic [7:0] attr, int unsigned space_pct);
    for (int i = 0; i < EntryBytes; i++) ent[i] = 8'($urandom);
    for (int i = 1; i < 11; i++) begin
      if ($urandom_range(99) < space_pct) ent[i] = SpaceChar;
    end
    ent[0]       = first;
    ent[AttrOfs] = attr;
  endtask

  task automatic zero_cluster();
    ent[ClusLoOfs]     = 8'h00;
    ent[ClusLoOfs + 1] = 8'h00;
    ent[ClusHiOfs]     = 8'h00;
    ent[ClusHiOfs + 1] = 8'h00;
  endtask

  task automatic push_entry(logic rs, int unsigned nbytes);
    for (int i = 0; i < nbytes; i++) push_byte(rs && i == 0, ent[i]);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    case (idx)
      CfgFat32Mode:   m_fat32 = val[0];
      CfgRootCluster: m_root  = val[RootW-1:0];
      CfgEntryLimit:  m_limit = val[IdxW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic fat32, logic [RootW-1:0] root, logic [IdxW-1:0] limit);
    write_reg(CfgFat32Mode, CfgDataW'(fat32));
    write_reg(CfgRootCluster, CfgDataW'(root));
    write_reg(CfgEntryLimit, CfgDataW'(limit));
  endtask

  // Waits until every byte is taken and every result has come, then lets the block go quiet.
  task automatic settle();
    while (n_accepted != n_pushed || name_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Driver: presents queued bytes, holding each until it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid    <= 1'b0;
      in_if.restart  <= 1'b0;
      in_if.dir_byte <= 8'h00;
    end else begin
      if (in_if.valid && in_if.ready) begin
        scan_byte(in_if.restart, in_if.dir_byte);
        n_accepted <= n_accepted + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (byte_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          drv_item = byte_queue.pop_front();
          in_if.valid    <= 1'b1;
          in_if.restart  <= drv_item.restart;
          in_if.dir_byte <= drv_item.dir_byte;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (name_results.size() == 0) begin
          $error("unexpected result: kind %0d name_char %0h", out_if.kind, out_if.name_char);
          n_errors++;
        end else begin
          want = name_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_if.kind));
          check_field("name_char", 32'(want.name_char), 32'(out_if.name_char));
          check_field("is_directory", 32'(want.is_dir), 32'(out_if.is_directory));
          check_field("file_length", want.len, out_if.file_length);
          check_field("first_cluster", want.clus, out_if.first_cluster);
          check_field("last", 32'(want.last), 32'(out_if.last));
        end
      end
      out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Long receiver hold-off, started once on request and counted down here.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_spent) begin
      hold_left  <= HoldCycles;
      hold_spent <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CycleLimit) begin
      $display("fat_dir_entry_scanner_core test failed");
      $finish;
    end
  end

  initial begin
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = CfgFat32Mode;
    cfg_wdata = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // FAT16 with the widest root cluster and the largest limit; receiver idles more.
    src_idle_pct = 33;
    snk_idle_pct = 86;
    set_config(1'b0, {RootW{1'b1}}, LimitReset);
    // Escaped first byte, embedded spaces, high cluster word that FAT16 ignores.
    fill_entry(KanjiEsc, 8'h20, 30);
    ent[ClusHiOfs]     = 8'hFF;
    ent[ClusHiOfs + 1] = 8'hFF;
    push_entry(1'b1, EntryBytes);
    fill_entry(DeletedMark, 8'h00, 0);
    push_entry(1'b0, EntryBytes);
    fill_entry(8'h41, 8'h0F, 0);
    push_entry(1'b0, EntryBytes);
    // Directory whose extension is blank, so the trailing dot goes; a zero byte in the name.
    fill_entry(DotChar, AttrDir, 0);
    ent[1] = EndByte;
    for (int i = 2; i < 11; i++) ent[i] = SpaceChar;
    push_entry(1'b0, EntryBytes);
    push_byte(1'b0, EndByte);
    push_byte(1'b0, 8'hFF);
    push_byte(1'b0, EndByte);
    // Restart after the scan finished, then again in the middle of an entry.
    fill_entry(8'h42, 8'h00, 20);
    push_entry(1'b1, 10);
    fill_entry(8'h43, AttrDir, 20);
    push_entry(1'b1, EntryBytes);
    push_byte(1'b0, EndByte);
    repeat (6) push_byte(1'b1, EndByte);
    settle();

    // FAT32 with root cluster zero and a limit of one entry; sender idles more.
    src_idle_pct = 86;
    snk_idle_pct = 33;
    set_config(1'b1, '0, 10'd1);
    fill_entry(8'h44, 8'h00, 0);
    zero_cluster();
    push_entry(1'b1, EntryBytes);
    push_byte(1'b0, 8'h41);
    push_byte(1'b0, 8'h42);
    fill_entry(8'h45, AttrDir, 0);
    for (int i = 0; i < 2; i++) begin
      ent[ClusLoOfs + i] = 8'hFF;
      ent[ClusHiOfs + i] = 8'hFF;
    end
    push_entry(1'b1, EntryBytes);
    push_byte(1'b0, 8'h41);
    settle();

    // Widest root cluster substituted, limit of two, then a limit of zero; no idling.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    set_config(1'b1, {RootW{1'b1}}, 10'd2);
    fill_entry(8'h46, 8'h00, 50);
    zero_cluster();
    push_entry(1'b1, EntryBytes);
    push_byte(1'b0, EndByte);
    settle();
    write_reg(CfgEntryLimit, '0);
    push_byte(1'b1, 8'h41);
    push_byte(1'b0, 8'h41);
    settle();

    // Receiver stalls for a long stretch so the entry queue fills and the input backs up.
    @(negedge clk_i);
    hold_req = 1'b1;
    repeat (20) push_byte(1'b1, EndByte);
    settle();

    if (n_errors == 0) begin
      $display("fat_dir_entry_scanner_core test passed");
    end else begin
      $display("fat_dir_entry_scanner_core test failed");
    end
    $finish;
  end

endmodule
